// ===== hdl/lfu_pkg.sv =====
// lfu_pkg: command codes, update opcodes and fixed constants for the lfu cache
// used by lfu_cell and lfu_cache_policy; no dependencies
package lfu_pkg;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // value reported when no stored value is returned
    localparam logic [31:0] READ_MISS = 32'hFFFF_FFFF;

    localparam int CAP_WIDTH = 5;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

    // update broadcast to all cells at the end of an item
    typedef enum logic [1:0] {
        UPD_TOUCH,
        UPD_REPLACE,
        UPD_INSERT
    } upd_op_t;

endpackage

// ===== hdl/lfu_cache_policy.sv =====
// lfu_cache_policy: key-value store with least-frequently-used replacement
// depends on lfu_pkg and lfu_cell
//
// An item is accepted only while the block is idle. A token then walks the row of entry
// cells one cell per cycle, collecting the key match, the eviction candidate (lowest
// count, then least recently used), the first free slot and the occupancy; any update is
// then broadcast to all cells while the result is registered. One item is in work at a
// time; the next is accepted as soon as the result is registered, even while that result
// still waits to be taken, and it then holds in its last step until the result register
// frees up.
module lfu_cache_policy
    import lfu_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CAP_WIDTH-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic signed [31:0]   key,
    input  logic signed [31:0]   value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic signed [31:0]   read_value,
    output logic                 evicted,
    output logic signed [31:0]   evicted_key
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CAPW = (OW > CAP_WIDTH) ? OW : CAP_WIDTH;
    localparam logic [CAPW-1:0] N_EXT = CAPW'(ENTRIES);

    typedef struct packed {
        logic                   act;
        logic                   hit;
        logic [31:0]            hit_val;
        logic [IW-1:0]          hit_idx;
        logic [IW-1:0]          hit_rank;
        logic                   vic_ok;
        logic [COUNT_WIDTH-1:0] vic_cnt;
        logic [IW-1:0]          vic_rank;
        logic [IW-1:0]          vic_idx;
        logic [31:0]            vic_key;
        logic                   free_ok;
        logic [IW-1:0]          free_idx;
        logic [OW-1:0]          occ;
    } tok_t;

    typedef struct packed {
        logic          en;
        upd_op_t       op;
        logic [IW-1:0] target;
        logic          close_en;
        logic [IW-1:0] close_rank;
        logic [IW-1:0] new_rank;
        logic          wr_val;
        logic [31:0]   key;
        logic [31:0]   value;
    } upd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED,
        S_SWEEP,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CAP_WIDTH-1:0]   cap_reg;
    logic                   cmd_reg;
    logic [31:0]            key_reg;
    logic [31:0]            val_reg;
    tok_t                   tail_reg;
    logic                   out_valid_reg;
    logic                   hit_reg;
    logic [31:0]            rd_reg;
    logic                   ev_reg;
    logic [31:0]            evk_reg;

    tok_t                   chain [ENTRIES+1];
    upd_t                   upd;
    logic                   finish;
    logic [CAPW-1:0]        cap_eff;
    logic [CAPW-1:0]        occ_ext;
    logic [IW-1:0]          top_rank;
    logic                   rd_hit;
    logic                   ev_now;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = rd_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evk_reg;

    // token seed enters the first cell
    always_comb
    begin
        chain[0]     = '0;
        chain[0].act = (state_reg == S_SEED);
    end

    // row of entry cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lfu_cell #(
            .ENTRIES     (ENTRIES),
            .COUNT_WIDTH (COUNT_WIDTH),
            .IDX         (i),
            .tok_t       (tok_t),
            .upd_t       (upd_t)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .key_in  (key_reg),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1]),
            .upd     (upd)
        );
    end

    // decide the update from the collected token
    always_comb
    begin
        cap_eff  = (CAPW'(cap_reg) > N_EXT) ? N_EXT : CAPW'(cap_reg);
        occ_ext  = CAPW'(tail_reg.occ);
        top_rank = IW'(tail_reg.occ - 1'b1);
        finish   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
        rd_hit   = (cmd_reg == CMD_GET) && tail_reg.hit;
        ev_now   = 1'b0;

        upd            = '0;
        upd.op         = UPD_TOUCH;
        upd.key        = key_reg;
        upd.value      = val_reg;
        upd.wr_val     = (cmd_reg == CMD_PUT);
        upd.target     = tail_reg.hit_idx;
        upd.close_en   = 1'b1;
        upd.close_rank = tail_reg.hit_rank;
        upd.new_rank   = top_rank;

        if (tail_reg.hit)
        begin
            upd.en = finish && ((cmd_reg == CMD_GET) || (cap_eff != '0));
        end
        else if ((cmd_reg == CMD_PUT) && (cap_eff != '0))
        begin
            upd.en = finish;
            if (occ_ext >= cap_eff)
            begin
                ev_now         = 1'b1;
                upd.op         = UPD_REPLACE;
                upd.target     = tail_reg.vic_idx;
                upd.close_rank = tail_reg.vic_rank;
            end
            else
            begin
                upd.op       = UPD_INSERT;
                upd.target   = tail_reg.free_idx;
                upd.close_en = 1'b0;
                upd.new_rank = IW'(tail_reg.occ);
            end
        end
    end

    // sequencer, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            // a new result may replace the one taken in the same cycle
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_SEED;
                    end
                end
                S_SEED:
                begin
                    state_reg <= S_SWEEP;
                end
                S_SWEEP:
                begin
                    if (chain[ENTRIES].act)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (finish)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            key_reg <= key;
            val_reg <= value;
        end
        if ((state_reg == S_SWEEP) && chain[ENTRIES].act)
        begin
            tail_reg <= chain[ENTRIES];
        end
        if (finish)
        begin
            hit_reg <= tail_reg.hit;
            rd_reg  <= rd_hit ? tail_reg.hit_val : READ_MISS;
            ev_reg  <= ev_now;
            evk_reg <= ev_now ? tail_reg.vic_key : 32'd0;
        end
    end

`ifndef SYNTHESIS
    a_tail_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        chain[ENTRIES].act |-> (state_reg == S_SWEEP))
        else $error("sweep token left the row outside the sweep");

    a_accept_seeds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SEED))
        else $error("accepted item did not start a sweep");

    a_upd_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        upd.en |-> ((state_reg == S_DONE) && (upd.target <= IW'(ENTRIES - 1))))
        else $error("update issued outside the done step or to a missing cell");

    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ev_reg) |-> !hit_reg)
        else $error("eviction reported for a hit");
`endif

endmodule

// ===== hdl/lfu_cell.sv =====
// lfu_cell: one cache entry plus one stage of the lookup/victim sweep token
// depends on lfu_pkg; token and update types come from the top level
module lfu_cell
    import lfu_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int COUNT_WIDTH = 16,
    parameter int IDX = 0,
    parameter type tok_t = logic,
    parameter type upd_t = logic
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] key_in,
    input  tok_t        tok_in,
    output tok_t        tok_out,
    input  upd_t        upd
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic                   valid_reg, valid_next;
    logic [31:0]            key_reg, key_next;
    logic [31:0]            val_reg, val_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [IW-1:0]          rank_reg, rank_next;
    tok_t                   tok_reg, tok_next;
    logic                   match;
    logic                   sel;

    assign match   = valid_reg && (key_reg == key_in);
    assign sel     = upd.en && (upd.target == MY_IDX);
    assign tok_out = tok_reg;

    // fold this entry into the passing token
    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg)
        begin
            tok_next.occ = tok_in.occ + 1'b1;
            if (match)
            begin
                tok_next.hit      = 1'b1;
                tok_next.hit_val  = val_reg;
                tok_next.hit_idx  = MY_IDX;
                tok_next.hit_rank = rank_reg;
            end
            if (!tok_in.vic_ok || (cnt_reg < tok_in.vic_cnt) ||
                ((cnt_reg == tok_in.vic_cnt) && (rank_reg < tok_in.vic_rank)))
            begin
                tok_next.vic_ok   = 1'b1;
                tok_next.vic_cnt  = cnt_reg;
                tok_next.vic_rank = rank_reg;
                tok_next.vic_idx  = MY_IDX;
                tok_next.vic_key  = key_reg;
            end
        end
        else if (!tok_in.free_ok)
        begin
            tok_next.free_ok  = 1'b1;
            tok_next.free_idx = MY_IDX;
        end
    end

    // apply the broadcast update
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        rank_next  = rank_reg;
        if (upd.en && valid_reg && !sel && upd.close_en && (rank_reg > upd.close_rank))
        begin
            rank_next = rank_reg - 1'b1;
        end
        if (sel)
        begin
            rank_next = upd.new_rank;
            case (upd.op)
                UPD_TOUCH:
                begin
                    if (cnt_reg != COUNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (upd.wr_val)
                    begin
                        val_next = upd.value;
                    end
                end
                UPD_REPLACE, UPD_INSERT:
                begin
                    valid_next = 1'b1;
                    key_next   = upd.key;
                    val_next   = upd.value;
                    cnt_next   = COUNT_ONE;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        val_reg  <= val_next;
        cnt_reg  <= cnt_next;
        rank_reg <= rank_next;
    end

endmodule
